// ----- design/two_operator_fm_oscillator_assert.svh -----
// Assertion macros used by the FM oscillator top-level design file.
`ifndef TWO_OPERATOR_FM_OSCILLATOR_ASSERT_SVH
`define TWO_OPERATOR_FM_OSCILLATOR_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TOFM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TOFM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tofm_pkg.sv -----
// Types and constants shared by the FM oscillator controller and datapath.
`timescale 1ns / 1ps

package tofm_pkg;

    // Register indexes on the configuration channel.
    localparam logic [2:0] REG_BASE_NOTE     = 3'd0;
    localparam logic [2:0] REG_RATIO         = 3'd1;
    localparam logic [2:0] REG_MOD_INDEX     = 3'd2;
    localparam logic [2:0] REG_FEEDBACK      = 3'd3;
    localparam logic [2:0] REG_PHASE_STEP    = 3'd4;

    localparam logic signed [16:0] BASE_NOTE_RST  = 17'sd17664;
    localparam logic [15:0]        RATIO_RST      = 16'd256;
    localparam logic [19:0]        PHASE_STEP_RST = 20'd89478;

    localparam logic [31:0] INC_MAX      = 32'd2104533975;
    localparam logic [31:0] INV_TWO_PI   = 32'd683565276;
    localparam logic [31:0] DIV3_RECIP   = 32'hAAAAAAAB;
    localparam logic signed [26:0] DIV_BIAS = 27'sd24035328;
    localparam logic [24:0] E_BIAS       = 25'd8388608;

    localparam logic [31:0] EXP_C3  = 32'd5138;
    localparam logic [31:0] EXP_C2  = 32'd14805;
    localparam logic [31:0] EXP_C1  = 32'd45593;
    localparam logic [31:0] EXP_ONE = 32'd65536;

    localparam logic [31:0] SIN_K9 = 32'd172274;
    localparam logic [31:0] SIN_K7 = 32'd5026956;
    localparam logic [31:0] SIN_K5 = 32'd85569227;
    localparam logic [31:0] SIN_K3 = 32'd693598605;
    localparam logic [31:0] SIN_K1 = 32'd1686629713;

    localparam logic [15:0] INDEX_MAX = 16'd40960;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIV, ST_H1, ST_H2, ST_H3, ST_BASE, ST_FB, ST_INC, ST_RAT,
        ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3, ST_SIN4, ST_SIN5, ST_SIN6,
        ST_IDX, ST_OFF, ST_CPH, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_DIV, OP_H1, OP_H2, OP_H3, OP_BASE, OP_FB, OP_RAT,
        OP_SQ, OP_T1, OP_T2, OP_T3, OP_T4, OP_T5, OP_IDX, OP_OFF
    } mul_op_t;

    typedef struct packed {
        mul_op_t op;
        logic    ld_in;
        logic    ld_e;
        logic    ld_base;
        logic    ld_inc;
        logic    ld_incm;
        logic    ld_u2;
        logic    ld_sin;
        logic    ld_lastmod;
        logic    ld_neg;
        logic    ld_cph;
        logic    ld_out;
    } cmd_t;

endpackage

// ----- design/tofm_ctrl.sv -----
// Sequencer that steps the shared multiplier through one sample's computation.
`timescale 1ns / 1ps

module tofm_ctrl
    import tofm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pass_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld_in  = 1'b1;
                    pass_next  = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.op     = OP_DIV;
                state_next = ST_H1;
            end
            ST_H1: begin
                cmd.op     = OP_H1;
                cmd.ld_e   = 1'b1;
                state_next = ST_H2;
            end
            ST_H2: begin
                cmd.op     = OP_H2;
                state_next = ST_H3;
            end
            ST_H3: begin
                cmd.op     = OP_H3;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                cmd.op     = OP_BASE;
                state_next = ST_FB;
            end
            ST_FB: begin
                cmd.op      = OP_FB;
                cmd.ld_base = 1'b1;
                state_next  = ST_INC;
            end
            ST_INC: begin
                cmd.ld_inc = 1'b1;
                state_next = ST_RAT;
            end
            ST_RAT: begin
                cmd.op     = OP_RAT;
                state_next = ST_SIN0;
            end
            ST_SIN0: begin
                cmd.op      = OP_SQ;
                cmd.ld_incm = !pass_reg;
                state_next  = ST_SIN1;
            end
            ST_SIN1: begin
                cmd.op     = OP_T1;
                cmd.ld_u2  = 1'b1;
                state_next = ST_SIN2;
            end
            ST_SIN2: begin
                cmd.op     = OP_T2;
                state_next = ST_SIN3;
            end
            ST_SIN3: begin
                cmd.op     = OP_T3;
                state_next = ST_SIN4;
            end
            ST_SIN4: begin
                cmd.op     = OP_T4;
                state_next = ST_SIN5;
            end
            ST_SIN5: begin
                cmd.op     = OP_T5;
                state_next = ST_SIN6;
            end
            ST_SIN6: begin
                cmd.ld_sin = 1'b1;
                state_next = pass_reg ? ST_OUT : ST_IDX;
            end
            ST_IDX: begin
                cmd.op         = OP_IDX;
                cmd.ld_lastmod = 1'b1;
                state_next     = ST_OFF;
            end
            ST_OFF: begin
                cmd.op     = OP_OFF;
                cmd.ld_neg = 1'b1;
                state_next = ST_CPH;
            end
            ST_CPH: begin
                cmd.ld_cph = 1'b1;
                pass_next  = 1'b1;
                state_next = ST_SIN0;
            end
            ST_OUT: begin
                // Hold here while an earlier result has not been taken.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.ld_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- design/tofm_datapath.sv -----
// Datapath: configuration registers, phase state, shared multiplier and sine evaluation.
`timescale 1ns / 1ps

module tofm_datapath
    import tofm_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  logic [31:0] s_tdata,
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int TB = SINE_TABLE_BITS;
    localparam logic [TB-2:0] QUARTER = (TB-1)'(1) << (TB - 2);
    localparam logic [TB-1:0] HALF    = TB'(1) << (TB - 1);

    logic signed [16:0] base_note_reg;
    logic [15:0]        ratio_reg;
    logic [15:0]        mod_index_reg;
    logic [15:0]        fb_amt_reg;
    logic [19:0]        psph_reg;

    logic [31:0]        car_phase_reg;
    logic [31:0]        mod_phase_reg;
    logic signed [15:0] last_mod_reg;

    logic signed [15:0] pitch_reg;
    logic signed [15:0] icv_reg;
    logic signed [24:0] e_reg;
    logic [46:0]        base_reg;
    logic [31:0]        inc_c_reg;
    logic [31:0]        inc_m_reg;
    logic [31:0]        sph_reg;
    logic [31:0]        u2_reg;
    logic signed [15:0] sin_reg;
    logic               neg_reg;
    logic [15:0]        out_reg;
    logic signed [65:0] p_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [31:0]        p_hi16;
    logic [31:0]        p_hi30;
    logic signed [26:0] x_s;
    logic [28:0]        psph440;
    logic [TB-2:0]      r;
    logic [TB-2:0]      rr;
    logic [30:0]        u;
    logic signed [19:0] idx_sum;
    logic [15:0]        idx;
    logic [30:0]        mag;
    logic [31:0]        off;
    logic [31:0]        off_s;
    logic signed [8:0]  ip;
    logic signed [8:0]  ip_m16;
    logic [7:0]         rs;
    logic [53:0]        lsh;
    logic [46:0]        rsh;
    logic [31:0]        inc_pre;
    logic [31:0]        inc_val;
    logic [47:0]        scaled;
    logic [16:0]        amp;
    logic [15:0]        amp_cap;
    logic signed [15:0] sin_val;

    assign cfg_ready = 1'b1;
    assign m_tdata   = out_reg;

    assign p_hi16 = p_reg[47:16];
    assign p_hi30 = p_reg[61:30];

    // Four times the note in Q.12, biased by a multiple of three so it stays positive.
    assign x_s = (27'(base_note_reg) <<< 6) + (27'(pitch_reg) <<< 5) + (27'(pitch_reg) <<< 4)
               + DIV_BIAS;
    assign psph440 = (29'(psph_reg) << 9) - (29'(psph_reg) << 6) - (29'(psph_reg) << 3);

    // Quarter-wave position of the phase being evaluated.
    assign r  = sph_reg[30 -: (TB - 1)];
    assign rr = (r <= QUARTER) ? r : (TB-1)'(HALF - TB'(r));
    assign u  = {rr, {(32 - TB){1'b0}}};

    assign idx_sum = 20'($signed({1'b0, mod_index_reg})) + (20'(icv_reg) <<< 2) + 20'(icv_reg);
    always_comb begin
        if (idx_sum < 20'sd0) begin
            idx = '0;
        end else if (idx_sum > 20'($signed({1'b0, INDEX_MAX}))) begin
            idx = INDEX_MAX;
        end else begin
            idx = idx_sum[15:0];
        end
    end

    assign mag   = p_reg[65] ? 31'(-p_reg) : p_reg[30:0];
    assign off   = p_reg[58:27];
    assign off_s = neg_reg ? (32'd0 - off) : off;

    // Scale the Q.16 mantissa by the octave, saturate, then hold at least one hertz.
    assign ip     = e_reg[24:16];
    assign ip_m16 = ip - 9'sd16;
    assign rs     = 8'(9'sd16 - ip);
    assign lsh    = {7'b0, base_reg} << ip_m16[2:0];
    assign rsh    = base_reg >> rs;
    always_comb begin
        if (!ip[8] && ip >= 9'sd16) begin
            inc_pre = (lsh > 54'(INC_MAX)) ? INC_MAX : lsh[31:0];
        end else begin
            inc_pre = (rsh > 47'(INC_MAX)) ? INC_MAX : rsh[31:0];
        end
        inc_val = (inc_pre < 32'(psph_reg)) ? 32'(psph_reg) : inc_pre;
    end

    assign scaled  = ({16'b0, p_hi30} << 15) - {16'b0, p_hi30} + 48'(32'h2000_0000);
    assign amp     = scaled[46:30];
    assign amp_cap = (amp > 17'd32767) ? 16'd32767 : amp[15:0];
    assign sin_val = sph_reg[31] ? -$signed(amp_cap) : $signed(amp_cap);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_DIV: begin
                mul_a = 33'(x_s[24:0]);
                mul_b = 33'(DIV3_RECIP);
            end
            OP_H1: begin
                mul_a = 33'(EXP_C3);
                mul_b = 33'(p_reg[48:33]);
            end
            OP_H2: begin
                mul_a = 33'(EXP_C2 + p_hi16);
                mul_b = 33'(e_reg[15:0]);
            end
            OP_H3: begin
                mul_a = 33'(EXP_C1 + p_hi16);
                mul_b = 33'(e_reg[15:0]);
            end
            OP_BASE: begin
                mul_a = 33'(EXP_ONE + p_hi16);
                mul_b = 33'(psph440);
            end
            OP_FB: begin
                mul_a = 33'(fb_amt_reg);
                mul_b = 33'(last_mod_reg);
            end
            OP_RAT: begin
                mul_a = 33'(inc_c_reg);
                mul_b = 33'(ratio_reg);
            end
            OP_SQ: begin
                mul_a = 33'(u);
                mul_b = 33'(u);
            end
            OP_T1: begin
                mul_a = 33'(p_hi30);
                mul_b = 33'(SIN_K9);
            end
            OP_T2: begin
                mul_a = 33'(u2_reg);
                mul_b = 33'(SIN_K7 - p_hi30);
            end
            OP_T3: begin
                mul_a = 33'(u2_reg);
                mul_b = 33'(SIN_K5 - p_hi30);
            end
            OP_T4: begin
                mul_a = 33'(u2_reg);
                mul_b = 33'(SIN_K3 - p_hi30);
            end
            OP_T5: begin
                mul_a = 33'(u);
                mul_b = 33'(SIN_K1 - p_hi30);
            end
            OP_IDX: begin
                mul_a = 33'(idx);
                mul_b = 33'(sin_reg);
            end
            OP_OFF: begin
                mul_a = 33'(mag);
                mul_b = 33'(INV_TWO_PI);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
        if (cmd.ld_in) begin
            pitch_reg <= s_tdata[15:0];
            icv_reg   <= s_tdata[31:16];
        end
        if (cmd.ld_e) begin
            e_reg <= $signed({1'b0, p_reg[56:33]}) - $signed(E_BIAS);
        end
        if (cmd.ld_base) begin
            base_reg <= p_reg[46:0];
        end
        if (cmd.ld_inc) begin
            inc_c_reg <= inc_val;
        end
        if (cmd.ld_incm) begin
            inc_m_reg <= p_reg[39:8];
        end
        if (cmd.ld_inc) begin
            sph_reg <= mod_phase_reg + {p_reg[30:0], 1'b0};
        end else if (cmd.ld_cph) begin
            sph_reg <= car_phase_reg + off_s;
        end
        if (cmd.ld_u2) begin
            u2_reg <= p_hi30;
        end
        if (cmd.ld_sin) begin
            sin_reg <= sin_val;
        end
        if (cmd.ld_neg) begin
            neg_reg <= p_reg[65];
        end
        if (cmd.ld_out) begin
            out_reg <= sin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_note_reg <= BASE_NOTE_RST;
            ratio_reg     <= RATIO_RST;
            mod_index_reg <= '0;
            fb_amt_reg    <= '0;
            psph_reg      <= PHASE_STEP_RST;
            car_phase_reg <= '0;
            mod_phase_reg <= '0;
            last_mod_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_BASE_NOTE:  base_note_reg <= cfg_data[16:0];
                    REG_RATIO:      ratio_reg     <= cfg_data[15:0];
                    REG_MOD_INDEX:  mod_index_reg <= cfg_data[15:0];
                    REG_FEEDBACK:   fb_amt_reg    <= cfg_data[15:0];
                    REG_PHASE_STEP: psph_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.ld_lastmod) begin
                last_mod_reg <= sin_reg;
            end
            if (cmd.ld_out) begin
                car_phase_reg <= car_phase_reg + inc_c_reg;
                mod_phase_reg <= mod_phase_reg + inc_m_reg;
            end
        end
    end

endmodule

// ----- design/two_operator_fm_oscillator.sv -----
// The block works on one sample at a time; a single shared 33x33 multiplier
// computes 21 dependent products per sample in sequence.
// A new request is taken while the previous result still waits on m_.
// Reset (aresetn low, synchronous) restores the register defaults and clears phases,
// the feedback sample and the output valid flag.
`timescale 1ns / 1ps

`include "two_operator_fm_oscillator_assert.svh"

module two_operator_fm_oscillator
    import tofm_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] pitch_cv, [31:16] index_cv
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    cmd_t cmd;

    tofm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tofm_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // A request is taken only with nothing in flight.
    `TOFM_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request accepted while busy")
    // A result must never overwrite one that has not been taken.
    `TOFM_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.ld_out, !m_tvalid || m_tready, "pending result overwritten")
    // Loading the output always presents a valid result next cycle.
    `TOFM_ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.ld_out, m_tvalid, "loaded result not presented")
    // The sine phase register has a single source per cycle.
    `TOFM_ASSERT_IMPL(a_phase_src, aclk, aresetn, cmd.ld_inc, !cmd.ld_cph && !cmd.ld_out, "phase sources collide")

endmodule
